### rtl/spic_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spic_pkg;

    localparam int DATA_W        = 24;
    localparam int REG_W         = 23;
    localparam int ERR_W         = DATA_W + 1;
    localparam int DT_W          = 16;
    localparam int HI_W          = ERR_W + 2;
    localparam int PROD_W        = HI_W + REG_W;
    localparam int CNT_W         = $clog2(REG_W);
    localparam int CFG_IDX_W     = 3;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [REG_W-1:0] RST_SPEED_LIMIT = 23'd262144;
    localparam logic [REG_W-1:0] RST_PROP_GAIN   = 23'd78643;
    localparam logic [REG_W-1:0] RST_INTEG_GAIN  = 23'd22938;
    localparam logic [REG_W-1:0] RST_INTEG_LIMIT = 23'd262144;
    localparam logic [REG_W-1:0] RST_ACCEL_LIMIT = 23'd131072;
    localparam logic [REG_W-1:0] RST_DECEL_LIMIT = 23'd196608;

    localparam logic OP_STEP  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPEED_LIMIT = 3'd0,
        REG_PROP_GAIN   = 3'd1,
        REG_INTEG_GAIN  = 3'd2,
        REG_INTEG_LIMIT = 3'd3,
        REG_ACCEL_LIMIT = 3'd4,
        REG_DECEL_LIMIT = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [REG_W-1:0] speed_limit;
        logic [REG_W-1:0] prop_gain;
        logic [REG_W-1:0] integ_gain;
        logic [REG_W-1:0] integ_limit;
        logic [REG_W-1:0] accel_limit;
        logic [REG_W-1:0] decel_limit;
    } t_cfg;

    typedef struct packed {
        logic clear;
        logic en;
        logic bit_a;
        logic bit_b;
    } t_mac_ctl;

endpackage

`default_nettype wire

### rtl/speed_pi_controller_antiwindup_unit.sv
// Speed PI controller with conditional-integration anti-windup, signed fixed
// point with FRAC_BITS fraction bits. Input items arrive on the s_ channel:
// s_tuser selects a control step or an integral clear, s_tdata carries the
// target speed, measured speed and time step. Each item yields exactly one
// result item on the m_ channel: m_tdata is the acceleration command and
// m_tuser is set when the integral was held back by anti-windup.
// A control step multiplies bit-serially in a shared shift-and-add unit:
// first error times time step, then the gain sum. When the integral is
// held, the gain sum is run again with the old integral. A clear item, or
// a step with a zero time step, goes straight to the final state. A new
// item is accepted only after the previous result has moved to the output
// register. The output register holds the result while m_tready is low;
// the unit waits in its final state until that register is free.
// Configuration writes take effect at once and clear the integral.
// Synchronous reset loads the default registers, zeroes the integral and
// empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module speed_pi_controller_antiwindup_unit
    import spic_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [63:0]          s_tdata,   // target_speed, measured_speed, time_step
    input  wire logic                 s_tuser,   // op
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [DATA_W-1:0]         m_tdata,   // accel_cmd
    output logic                      m_tuser,   // integ_held
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [REG_W-1:0]     i_cfg_wdata
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_MUL_DT = 7'b0000010,
        ST_CAND   = 7'b0000100,
        ST_MUL_PI = 7'b0001000,
        ST_ROUND  = 7'b0010000,
        ST_DECIDE = 7'b0100000,
        ST_DONE   = 7'b1000000
    } t_state;

    t_cfg     w_cfg;
    logic     w_cfg_hit;
    t_mac_ctl w_mac;
    logic signed [PROD_W-1:0] w_prod;

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic signed [DATA_W-1:0] r_integ, n_integ;
    logic                     r_m_valid, n_m_valid;
    logic signed [ERR_W-1:0]  r_err, n_err;
    logic signed [DATA_W-1:0] r_cand, n_cand;
    logic                     r_second, n_second;
    logic [DATA_W-1:0]        r_res, n_res;
    logic                     r_held, n_held;
    logic signed [PROD_W-1:0] r_round, n_round;
    logic [REG_W-1:0]         r_mplr_a, n_mplr_a;
    logic [REG_W-1:0]         r_mplr_b, n_mplr_b;
    logic [DATA_W-1:0]        r_m_data, n_m_data;
    logic                     r_m_held, n_m_held;

    logic                     w_accept;
    logic signed [DATA_W-1:0] w_target;
    logic signed [DATA_W-1:0] w_meas;
    logic [DT_W-1:0]          w_dt;
    logic signed [DATA_W-1:0] w_tclamp;
    logic signed [ERR_W-1:0]  w_err;
    logic signed [HI_W-1:0]   w_step_term;
    logic signed [HI_W-1:0]   w_cand_sum;
    logic signed [HI_W-1:0]   w_ilim;
    logic signed [DATA_W-1:0] w_cand;
    logic signed [PROD_W-1:0] w_round;
    logic signed [PROD_W-1:0] w_acc_ext;
    logic signed [PROD_W-1:0] w_dec_ext;
    logic                     w_sat_hi;
    logic                     w_sat_lo;
    logic                     w_commit;
    logic [DATA_W-1:0]        w_clamped;
    logic                     w_out_free;

    spic_cfg_regs u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_we     (i_cfg_we),
        .i_idx    (i_cfg_idx),
        .i_wdata  (i_cfg_wdata),
        .o_cfg    (w_cfg),
        .o_wr_hit (w_cfg_hit)
    );

    spic_sermac u_mac (
        .i_clk     (i_clk),
        .i_ctl     (w_mac),
        .i_mcand_a (r_err),
        .i_mcand_b (r_second ? {r_integ[DATA_W-1], r_integ} : {r_cand[DATA_W-1], r_cand}),
        .o_prod    (w_prod)
    );

    assign s_tready   = (r_state == ST_IDLE);
    assign w_accept   = s_tvalid && s_tready;
    assign m_tvalid   = r_m_valid;
    assign m_tdata    = r_m_data;
    assign m_tuser    = r_m_held;
    assign w_out_free = !r_m_valid || m_tready;

    always_comb begin
        w_target = $signed(s_tdata[23:0]);
        w_meas   = $signed(s_tdata[47:24]);
        w_dt     = s_tdata[63:48];
        if (w_target[DATA_W-1]) begin
            w_tclamp = '0;
        end else if (w_target > $signed({1'b0, w_cfg.speed_limit})) begin
            w_tclamp = $signed({1'b0, w_cfg.speed_limit});
        end else begin
            w_tclamp = w_target;
        end
        w_err = {w_tclamp[DATA_W-1], w_tclamp} - {w_meas[DATA_W-1], w_meas};

        w_step_term = $signed(w_prod[PROD_W-1:REG_W])
                    + $signed({{(HI_W - 1){1'b0}}, w_prod[REG_W-1]});
        w_cand_sum  = {{(HI_W - DATA_W){r_integ[DATA_W-1]}}, r_integ} + w_step_term;
        w_ilim      = $signed({{(HI_W - REG_W){1'b0}}, w_cfg.integ_limit});
        if (w_cand_sum > w_ilim) begin
            w_cand = w_ilim[DATA_W-1:0];
        end else if (w_cand_sum < -w_ilim) begin
            w_cand = DATA_W'(-w_ilim);
        end else begin
            w_cand = w_cand_sum[DATA_W-1:0];
        end

        w_round = (w_prod >>> FRAC_BITS)
                + $signed({{(PROD_W - 1){1'b0}}, w_prod[FRAC_BITS-1]});

        w_acc_ext = $signed({{(PROD_W - REG_W){1'b0}}, w_cfg.accel_limit});
        w_dec_ext = $signed({{(PROD_W - REG_W){1'b0}}, w_cfg.decel_limit});
        w_sat_hi  = r_round > w_acc_ext;
        w_sat_lo  = r_round < -w_dec_ext;
        w_commit  = (!w_sat_hi || r_err[ERR_W-1])
                 && (!w_sat_lo || (!r_err[ERR_W-1] && (r_err != '0)));
        if (w_sat_hi) begin
            w_clamped = {1'b0, w_cfg.accel_limit};
        end else if (w_sat_lo) begin
            w_clamped = DATA_W'(-w_dec_ext);
        end else begin
            w_clamped = r_round[DATA_W-1:0];
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_integ   = r_integ;
        n_m_valid = r_m_valid;
        n_err     = r_err;
        n_cand    = r_cand;
        n_second  = r_second;
        n_res     = r_res;
        n_held    = r_held;
        n_round   = r_round;
        n_mplr_a  = r_mplr_a;
        n_mplr_b  = r_mplr_b;
        n_m_data  = r_m_data;
        n_m_held  = r_m_held;
        w_mac     = '0;

        if (r_m_valid && m_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_res  = '0;
                    n_held = 1'b0;
                    if (s_tuser == OP_CLEAR) begin
                        n_integ = '0;
                        n_state = ST_DONE;
                    end else if (w_dt == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        n_err     = w_err;
                        n_second  = 1'b0;
                        n_mplr_a  = REG_W'(w_dt);
                        n_mplr_b  = '0;
                        n_cnt     = '0;
                        w_mac.clear = 1'b1;
                        n_state   = ST_MUL_DT;
                    end
                end
            end
            ST_MUL_DT, ST_MUL_PI: begin
                w_mac.en    = 1'b1;
                w_mac.bit_a = r_mplr_a[0];
                w_mac.bit_b = r_mplr_b[0];
                n_mplr_a    = r_mplr_a >> 1;
                n_mplr_b    = r_mplr_b >> 1;
                n_cnt       = r_cnt + 1'b1;
                if (r_state == ST_MUL_DT && r_cnt == CNT_W'(DT_W - 1)) begin
                    n_state = ST_CAND;
                end else if (r_state == ST_MUL_PI && r_cnt == CNT_W'(REG_W - 1)) begin
                    n_state = ST_ROUND;
                end
            end
            ST_CAND: begin
                n_cand      = w_cand;
                n_mplr_a    = w_cfg.prop_gain;
                n_mplr_b    = w_cfg.integ_gain;
                n_cnt       = '0;
                w_mac.clear = 1'b1;
                n_state     = ST_MUL_PI;
            end
            ST_ROUND: begin
                n_round = w_round;
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (!r_second && !w_commit) begin
                    n_held      = 1'b1;
                    n_second    = 1'b1;
                    n_mplr_a    = w_cfg.prop_gain;
                    n_mplr_b    = w_cfg.integ_gain;
                    n_cnt       = '0;
                    w_mac.clear = 1'b1;
                    n_state     = ST_MUL_PI;
                end else begin
                    if (!r_second) begin
                        n_integ = r_cand;
                        n_held  = 1'b0;
                    end
                    n_res   = w_clamped;
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_m_valid = 1'b1;
                    n_m_data  = r_res;
                    n_m_held  = r_held;
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (w_cfg_hit) begin
            n_integ = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_integ   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_integ   <= n_integ;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt    <= n_cnt;
        r_err    <= n_err;
        r_cand   <= n_cand;
        r_second <= n_second;
        r_res    <= n_res;
        r_held   <= n_held;
        r_round  <= n_round;
        r_mplr_a <= n_mplr_a;
        r_mplr_b <= n_mplr_b;
        r_m_data <= n_m_data;
        r_m_held <= n_m_held;
    end

    a_cfg_clears_integ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_hit |=> (r_integ == '0))
        else $error("integral not cleared after a configuration write");

    a_clear_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (s_tuser == OP_CLEAR)) |=> (r_integ == '0))
        else $error("integral not cleared by a clear item");

    a_integ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_integ <= $signed({1'b0, w_cfg.integ_limit}))
        && (r_integ >= -$signed({1'b0, w_cfg.integ_limit})))
        else $error("integral outside its limit");

    a_out_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (($signed(m_tdata) <= $signed({1'b0, w_cfg.accel_limit}))
                   && ($signed(m_tdata) >= -$signed({1'b0, w_cfg.decel_limit}))))
        else $error("acceleration command outside its limits");

    a_done_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DONE) && w_out_free) |=> m_tvalid)
        else $error("finished item not moved to the output register");

endmodule

`default_nettype wire

### rtl/spic_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module spic_cfg_regs
    import spic_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_we,
    input  wire logic [CFG_IDX_W-1:0] i_idx,
    input  wire logic [REG_W-1:0]     i_wdata,
    output t_cfg                      o_cfg,
    output logic                      o_wr_hit
);

    t_cfg r_cfg;

    assign o_cfg    = r_cfg;
    assign o_wr_hit = i_we && (i_idx inside {[REG_SPEED_LIMIT:REG_DECEL_LIMIT]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed_limit <= RST_SPEED_LIMIT;
            r_cfg.prop_gain   <= RST_PROP_GAIN;
            r_cfg.integ_gain  <= RST_INTEG_GAIN;
            r_cfg.integ_limit <= RST_INTEG_LIMIT;
            r_cfg.accel_limit <= RST_ACCEL_LIMIT;
            r_cfg.decel_limit <= RST_DECEL_LIMIT;
        end else if (i_we) begin
            case (t_reg_idx'(i_idx))
                REG_SPEED_LIMIT: r_cfg.speed_limit <= i_wdata;
                REG_PROP_GAIN:   r_cfg.prop_gain   <= i_wdata;
                REG_INTEG_GAIN:  r_cfg.integ_gain  <= i_wdata;
                REG_INTEG_LIMIT: r_cfg.integ_limit <= i_wdata;
                REG_ACCEL_LIMIT: r_cfg.accel_limit <= i_wdata;
                REG_DECEL_LIMIT: r_cfg.decel_limit <= i_wdata;
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/spic_sermac.sv
`timescale 1ns / 1ps
`default_nettype none

// Serial-parallel multiply-accumulate: one multiplier bit per cycle while enabled for each of
// two products, the partial sum shifting right into the low register.
module spic_sermac
    import spic_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire t_mac_ctl                 i_ctl,
    input  wire logic signed [ERR_W-1:0]  i_mcand_a,
    input  wire logic signed [ERR_W-1:0]  i_mcand_b,
    output logic signed [PROD_W-1:0]      o_prod
);

    logic signed [HI_W-1:0] r_hi;
    logic signed [HI_W-1:0] n_hi;
    logic [REG_W-1:0]       r_lo;
    logic [REG_W-1:0]       n_lo;
    logic signed [HI_W:0]   w_add_a;
    logic signed [HI_W:0]   w_add_b;
    logic signed [HI_W:0]   w_sum;

    always_comb begin
        w_add_a = i_ctl.bit_a ? {{(HI_W + 1 - ERR_W){i_mcand_a[ERR_W-1]}}, i_mcand_a} : '0;
        w_add_b = i_ctl.bit_b ? {{(HI_W + 1 - ERR_W){i_mcand_b[ERR_W-1]}}, i_mcand_b} : '0;
        w_sum   = {r_hi[HI_W-1], r_hi} + w_add_a + w_add_b;
        n_hi    = r_hi;
        n_lo    = r_lo;
        if (i_ctl.clear) begin
            n_hi = '0;
            n_lo = '0;
        end else if (i_ctl.en) begin
            n_hi = w_sum[HI_W:1];
            n_lo = {w_sum[0], r_lo[REG_W-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_hi <= n_hi;
        r_lo <= n_lo;
    end

    assign o_prod = {r_hi, r_lo};

endmodule

`default_nettype wire
